@@ design/pwa_pkg.sv @@
// Package of shared types and codes for the partitioned word allocator.
package pwa_pkg;

    // Command codes
    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_CLEAN = 3'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_ALIGN   = 3'd2;
    localparam logic [2:0] ST_NOALLOC = 3'd3;
    localparam logic [2:0] ST_NOREAD  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_BADCMD  = 3'd6;

    // Decoded operation kind
    typedef enum logic [2:0] {
        K_ALLOC,
        K_READ,
        K_WRITE,
        K_CLEAN,
        K_NONE
    } t_kind;

    // Request as it arrives on the input port
    typedef struct packed {
        logic [2:0]         cmd;
        logic [1:0]         partition;
        logic signed [15:0] byte_address;
        logic signed [31:0] write_value;
    } t_request;

    // Result as it leaves on the output port
    typedef struct packed {
        logic [2:0]         status;
        logic [9:0]         alloc_address;
        logic signed [31:0] read_data;
    } t_result;

    // Classified request held in the queue between front and back
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  status;
        logic [1:0]  partition;
        logic [15:0] byte_address;
        logic [31:0] write_value;
    } t_op;

endpackage

@@ design/partitioned_word_allocator_top.sv @@
// Top level of the partitioned word allocator: front end, request queue, back end.
//
// Usage:
//   A request (i_request: cmd, partition, byte_address, write_value) is taken
//   at a rising edge where start is high and busy is low. The front end
//   decodes it and checks the address range and alignment, then pushes it
//   into a short queue. The back end pops one request per cycle, checks and
//   updates the valid and written marks, accesses the word store, and puts
//   exactly one result (status, alloc_address, read_data) on o_result with
//   o_strobe high for one cycle.
//   An accepted request is written into the queue; when the back end pops it,
//   its result is registered onto o_result; results keep request order.
//   Throughput: one request per cycle while busy is low; the word store has a
//   write and a read port, and the first-free search over a partition's marks
//   is combinational. busy is high only while the queue is full.
//   Reset clears all valid and written marks, the queue and the strobe at
//   once; the word store is not cleared. The receiver cannot stall results.
module partitioned_word_allocator_top #(
    parameter int TOTAL_WORDS     = 256,
    parameter int PARTITION_COUNT = 4,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pwa_pkg::t_request i_request,
    output logic              o_strobe,
    output pwa_pkg::t_result  o_result
);

    pwa_pkg::t_op front_op;
    pwa_pkg::t_op queue_op;
    logic         q_empty;
    logic         q_full;
    logic         q_pop;
    logic         accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    pwa_front #(
        .TOTAL_WORDS    (TOTAL_WORDS),
        .PARTITION_COUNT(PARTITION_COUNT)
    ) u_front (
        .i_request(i_request),
        .o_op     (front_op)
    );

    pwa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_op   (front_op),
        .i_pop  (q_pop),
        .o_op   (queue_op),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    pwa_back #(
        .TOTAL_WORDS    (TOTAL_WORDS),
        .PARTITION_COUNT(PARTITION_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (queue_op),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule

@@ design/pwa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pwa_front.sv @@
// Front end: decodes a request and runs the address range and alignment checks.
module pwa_front #(
    parameter int TOTAL_WORDS     = 256,
    parameter int PARTITION_COUNT = 4
) (
    input  pwa_pkg::t_request i_request,
    output pwa_pkg::t_op      o_op
);

    localparam logic [15:0] AddrLimit = 16'(TOTAL_WORDS * 4);

    logic [15:0] addr;
    logic [2:0]  addr_status;
    logic [1:0]  part;

    assign addr = i_request.byte_address;

    // range first, then alignment
    always_comb begin
        if (addr[15] || (addr >= AddrLimit)) begin
            addr_status = pwa_pkg::ST_RANGE;
        end else if (addr[1:0] != 2'b00) begin
            addr_status = pwa_pkg::ST_ALIGN;
        end else begin
            addr_status = pwa_pkg::ST_OK;
        end
    end

    // partition numbers past the last partition fold onto it
    always_comb begin
        if (32'(i_request.partition) >= 32'(PARTITION_COUNT)) begin
            part = 2'(PARTITION_COUNT - 1);
        end else begin
            part = i_request.partition;
        end
    end

    // command decode
    always_comb begin
        o_op.partition    = part;
        o_op.byte_address = addr;
        o_op.write_value  = i_request.write_value;
        case (i_request.cmd)
            pwa_pkg::CMD_ALLOC: begin
                o_op.kind   = pwa_pkg::K_ALLOC;
                o_op.status = pwa_pkg::ST_OK;
            end
            pwa_pkg::CMD_READ: begin
                o_op.kind   = pwa_pkg::K_READ;
                o_op.status = addr_status;
            end
            pwa_pkg::CMD_WRITE: begin
                o_op.kind   = pwa_pkg::K_WRITE;
                o_op.status = addr_status;
            end
            pwa_pkg::CMD_CLEAN: begin
                o_op.kind   = pwa_pkg::K_CLEAN;
                o_op.status = pwa_pkg::ST_OK;
            end
            default: begin
                o_op.kind   = pwa_pkg::K_NONE;
                o_op.status = pwa_pkg::ST_BADCMD;
            end
        endcase
    end

endmodule

@@ design/pwa_queue.sv @@
// Short queue of classified requests between front and back.
module pwa_queue #(
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  pwa_pkg::t_op i_op,
    input  logic         i_pop,
    output pwa_pkg::t_op o_op,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    pwa_pkg::t_op      r_mem [DEPTH];
    logic [PtrW-1:0]   r_wptr;
    logic [PtrW-1:0]   r_rptr;
    logic [CntW-1:0]   r_count;
    logic [PtrW-1:0]   n_wptr;
    logic [PtrW-1:0]   n_rptr;
    logic [CntW-1:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_op    = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ design/pwa_back.sv @@
// Back end: keeps the marks, runs allocate/read/write/clean and issues results.
module pwa_back #(
    parameter int TOTAL_WORDS     = 256,
    parameter int PARTITION_COUNT = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwa_pkg::t_op     i_op,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_strobe,
    output pwa_pkg::t_result o_result
);

    localparam int WIW       = $clog2(TOTAL_WORDS);
    localparam int PartWords = TOTAL_WORDS / PARTITION_COUNT;
    localparam int PIW       = (PartWords > 1) ? $clog2(PartWords) : 1;
    localparam int NPSel     = (PARTITION_COUNT < 4) ? PARTITION_COUNT : 4;

    logic [TOTAL_WORDS-1:0] r_valid;
    logic [TOTAL_WORDS-1:0] r_written;
    logic [TOTAL_WORDS-1:0] n_valid;
    logic [TOTAL_WORDS-1:0] n_written;

    logic                   r_strobe;
    logic [2:0]             r_status;
    logic [9:0]             r_alloc_addr;
    logic                   r_rd_ok;
    logic [2:0]             n_status;
    logic [9:0]             n_alloc_addr;
    logic                   n_rd_ok;

    logic [PartWords-1:0]   free;
    logic [PartWords-1:0]   lowest;
    logic [PIW-1:0]         idx;
    logic                   found;
    logic [WIW-1:0]         base;
    logic [WIW-1:0]         alloc_word;
    logic [WIW-1:0]         word;
    logic                   ram_we;
    logic                   ram_re;
    logic [31:0]            ram_rdata;

    assign o_pop = !i_empty;
    assign word  = i_op.byte_address[WIW+1:2];

    // free marks of the chosen partition and its base word
    always_comb begin
        free = '0;
        base = '0;
        for (int k = 0; k < NPSel; k++) begin
            if (i_op.partition == 2'(k)) begin
                free = ~r_valid[k*PartWords +: PartWords];
                base = WIW'(k * PartWords);
            end
        end
    end

    // lowest free word: isolate lowest set bit, then encode it
    assign lowest = free & (~free + 1'b1);
    assign found  = |free;

    always_comb begin
        idx = '0;
        for (int i = 0; i < PartWords; i++) begin
            if (lowest[i]) begin
                idx = idx | PIW'(i);
            end
        end
    end

    assign alloc_word = base + WIW'(idx);

    // command execution
    always_comb begin
        n_valid      = r_valid;
        n_written    = r_written;
        n_status     = i_op.status;
        n_alloc_addr = '0;
        n_rd_ok      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (i_op.kind)
            pwa_pkg::K_ALLOC: begin
                if (found) begin
                    n_valid[alloc_word] = 1'b1;
                    n_alloc_addr        = 10'({alloc_word, 2'b00});
                    n_status            = pwa_pkg::ST_OK;
                end else begin
                    n_status = pwa_pkg::ST_FULL;
                end
            end
            pwa_pkg::K_READ: begin
                if (i_op.status == pwa_pkg::ST_OK) begin
                    if (!r_valid[word]) begin
                        n_status = pwa_pkg::ST_NOALLOC;
                    end else if (!r_written[word]) begin
                        n_status = pwa_pkg::ST_NOREAD;
                    end else begin
                        n_rd_ok = 1'b1;
                        ram_re  = o_pop;
                    end
                end
            end
            pwa_pkg::K_WRITE: begin
                if (i_op.status == pwa_pkg::ST_OK) begin
                    if (!r_valid[word]) begin
                        n_status = pwa_pkg::ST_NOALLOC;
                    end else begin
                        n_written[word] = 1'b1;
                        ram_we          = o_pop;
                    end
                end
            end
            pwa_pkg::K_CLEAN: begin
                for (int k = 0; k < NPSel; k++) begin
                    for (int i = 0; i < PartWords; i++) begin
                        if (i_op.partition == 2'(k)) begin
                            n_valid[k*PartWords + i]   = 1'b0;
                            n_written[k*PartWords + i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_status = pwa_pkg::ST_BADCMD;
            end
        endcase
    end

    // marks and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_written <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= o_pop;
            if (o_pop) begin
                r_valid   <= n_valid;
                r_written <= n_written;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status     <= n_status;
            r_alloc_addr <= n_alloc_addr;
            r_rd_ok      <= n_rd_ok;
        end
    end

    pwa_ram #(
        .WIDTH(32),
        .DEPTH(TOTAL_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(word),
        .i_wdata(i_op.write_value),
        .i_re   (ram_re),
        .i_raddr(word),
        .o_rdata(ram_rdata)
    );

    assign o_strobe               = r_strobe;
    assign o_result.status        = r_status;
    assign o_result.alloc_address = r_alloc_addr;
    assign o_result.read_data     = r_rd_ok ? ram_rdata : 32'sd0;

`ifndef SYNTHESIS
    a_result_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_strobe)
        else $error("request popped without a result");
    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.kind == pwa_pkg::K_ALLOC && found) |=> r_valid[$past(alloc_word)])
        else $error("allocated word not marked valid");
    a_read_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_rd_ok) |-> (r_status == pwa_pkg::ST_OK && $past(ram_re)))
        else $error("read data returned without a successful read");
`endif

endmodule

@@ test/tb_top.sv @@
// Testbench for the partitioned word allocator: random and directed requests, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int TOTAL_WORDS     = 256;
    localparam int PARTITION_COUNT = 4;
    localparam int PART_WORDS      = TOTAL_WORDS / PARTITION_COUNT;
    localparam int ADDR_SPAN       = TOTAL_WORDS * 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 285;
    localparam logic [2:0] CMD_FIRST_INVALID = 3'd4;
    localparam logic [2:0] CMD_LAST_INVALID  = 3'd7;

    // Shadow of the allocator state and the queue of results still to come
    class alloc_scoreboard;
        bit [TOTAL_WORDS-1:0] valid_marks;
        bit [TOTAL_WORDS-1:0] written_marks;
        logic [31:0]          word_store [TOTAL_WORDS];
        pwa_pkg::t_result     expected_results [$];
        int                   errors;

        function new();
            valid_marks   = '0;
            written_marks = '0;
            errors        = 0;
        endfunction

        // Range first, then alignment, then the valid mark
        function logic [2:0] address_status(logic [15:0] addr, output int word);
            word = 0;
            if (addr[15] || addr >= ADDR_SPAN)
                return pwa_pkg::ST_RANGE;
            if (addr[1:0] != 2'b00)
                return pwa_pkg::ST_ALIGN;
            word = int'(addr[15:2]);
            if (!valid_marks[word])
                return pwa_pkg::ST_NOALLOC;
            return pwa_pkg::ST_OK;
        endfunction

        function int partition_base(logic [1:0] part);
            int p;
            p = int'(part);
            if (p >= PARTITION_COUNT)
                p = PARTITION_COUNT - 1;
            return p * PART_WORDS;
        endfunction

        function pwa_pkg::t_result predict_outcome(pwa_pkg::t_request req);
            pwa_pkg::t_result res;
            int               base;
            int               word;
            res  = '0;
            word = 0;
            case (req.cmd)
                pwa_pkg::CMD_ALLOC: begin
                    base       = partition_base(req.partition);
                    res.status = pwa_pkg::ST_FULL;
                    for (int i = 0; i < PART_WORDS; i++) begin
                        if (!valid_marks[base + i]) begin
                            valid_marks[base + i] = 1'b1;
                            res.alloc_address     = 10'((base + i) * 4);
                            res.status            = pwa_pkg::ST_OK;
                            break;
                        end
                    end
                end
                pwa_pkg::CMD_READ: begin
                    res.status = address_status(req.byte_address, word);
                    if (res.status == pwa_pkg::ST_OK) begin
                        if (!written_marks[word])
                            res.status = pwa_pkg::ST_NOREAD;
                        else
                            res.read_data = word_store[word];
                    end
                end
                pwa_pkg::CMD_WRITE: begin
                    res.status = address_status(req.byte_address, word);
                    if (res.status == pwa_pkg::ST_OK) begin
                        word_store[word]    = req.write_value;
                        written_marks[word] = 1'b1;
                    end
                end
                pwa_pkg::CMD_CLEAN: begin
                    base = partition_base(req.partition);
                    for (int i = 0; i < PART_WORDS; i++) begin
                        valid_marks[base + i]   = 1'b0;
                        written_marks[base + i] = 1'b0;
                    end
                end
                default: res.status = pwa_pkg::ST_BADCMD;
            endcase
            return res;
        endfunction

        function void note_request(pwa_pkg::t_request req);
            expected_results.push_back(predict_outcome(req));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(pwa_pkg::t_result got);
            pwa_pkg::t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: status %0d",
                                          got.status));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.alloc_address !== want.alloc_address)
                report_mismatch($sformatf("alloc_address %0d, expected %0d",
                                          got.alloc_address, want.alloc_address));
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %h, expected %h",
                                          got.read_data, want.read_data));
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        // Byte address of some allocated word, or of any word if none is allocated
        function logic [15:0] random_live_address();
            int first;
            int idx;
            first = $urandom_range(TOTAL_WORDS - 1);
            for (int k = 0; k < TOTAL_WORDS; k++) begin
                idx = (first + k) % TOTAL_WORDS;
                if (valid_marks[idx])
                    return 16'(idx * 4);
            end
            return 16'($urandom_range(TOTAL_WORDS - 1) * 4);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    pwa_pkg::t_request i_request;
    logic              o_strobe;
    pwa_pkg::t_result  o_result;

    alloc_scoreboard sb;
    int              cycle_count = 0;

    partitioned_word_allocator_top #(
        .TOTAL_WORDS    (TOTAL_WORDS),
        .PARTITION_COUNT(PARTITION_COUNT)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Accepted requests and results, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(i_request);
            if (o_strobe)
                sb.check_result(o_result);
        end
    end

    function pwa_pkg::t_request mk(logic [2:0] cmd, logic [1:0] part, int addr,
                                   logic [31:0] value);
        pwa_pkg::t_request req;
        req.cmd          = cmd;
        req.partition    = part;
        req.byte_address = 16'(addr);
        req.write_value  = value;
        return req;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(pwa_pkg::t_request req, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off new requests until every pending result has come back
    task automatic wait_all_results();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic run_directed(int idle_pct);
        pwa_pkg::t_request reqs [$];
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_WRITE, 2'd0, -32768, 32'h1234_5678));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 32767,  32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 1024,   32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 2,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_WRITE, 2'd0, 1023,   32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_ALLOC, 2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_WRITE, 2'd0, 0,      32'h7fff_ffff));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_WRITE, 2'd0, 0,      32'h8000_0000));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_ALLOC, 2'd3, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_WRITE, 2'd0, 768,    32'hffff_ffff));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 768,    32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 1,      32'h0));
        for (logic [3:0] c = {1'b0, CMD_FIRST_INVALID}; c <= {1'b0, CMD_LAST_INVALID}; c++)
            reqs.push_back(mk(c[2:0], 2'd3, 0, 32'hffff_ffff));
        reqs.push_back(mk(pwa_pkg::CMD_CLEAN, 2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_CLEAN, 2'd1, 0,      32'h0));
        // written mark must not survive a clean and re-allocation
        reqs.push_back(mk(pwa_pkg::CMD_CLEAN, 2'd3, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_ALLOC, 2'd3, 0,      32'h0));
        reqs.push_back(mk(pwa_pkg::CMD_READ,  2'd0, 768,    32'h0));
        foreach (reqs[i])
            send_request(reqs[i], idle_pct);
    endtask

    // Mix of well-formed sessions, full-partition bursts, cleans, near misses and noise
    task automatic run_random(int n_items, int idle_pct);
        int          sent;
        int          pick;
        int          reps;
        logic [1:0]  part;
        logic [15:0] addr;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            part = 2'($urandom_range(PARTITION_COUNT - 1));
            if (pick < 40) begin
                send_request(mk(pwa_pkg::CMD_ALLOC, part, 0, 32'h0), idle_pct);
                sent++;
                reps = $urandom_range(1, 6);
                repeat (reps) begin
                    addr = sb.random_live_address();
                    if ($urandom_range(1))
                        send_request(mk(pwa_pkg::CMD_WRITE, part, int'(addr), $urandom),
                                     idle_pct);
                    else
                        send_request(mk(pwa_pkg::CMD_READ, part, int'(addr), $urandom),
                                     idle_pct);
                    sent++;
                end
            end else if (pick < 52) begin
                reps = $urandom_range(8, 70);
                repeat (reps) begin
                    send_request(mk(pwa_pkg::CMD_ALLOC, part, 0, $urandom), idle_pct);
                    sent++;
                end
            end else if (pick < 58) begin
                send_request(mk(pwa_pkg::CMD_CLEAN, part, $urandom, $urandom), idle_pct);
                sent++;
            end else if (pick < 78) begin
                addr = sb.random_live_address();
                case ($urandom_range(2))
                    0: addr = addr + 16'($urandom_range(1, 3));
                    1: addr = 16'($urandom_range(ADDR_SPAN, 32767));
                    default: addr = 16'h8000 | 16'($urandom_range(32767));
                endcase
                send_request(mk($urandom_range(1) ? pwa_pkg::CMD_READ : pwa_pkg::CMD_WRITE,
                                part, int'(addr), $urandom),
                             idle_pct);
                sent++;
            end else begin
                send_request(mk(3'($urandom_range(7)), part, $urandom, $urandom), idle_pct);
                sent++;
            end
        end
    endtask

    initial begin
        sb        = new();
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_request <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed(10);
        wait_all_results();
        run_random(PHASE_ITEMS, 10);
        run_random(PHASE_ITEMS, 82);
        run_random(PHASE_ITEMS, 0);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
